[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files that check themselves.
// Depends on nothing; expects aclk and aresetn in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define RHN_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");

// Checked at every clock edge, reset included.
`define RHN_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("assertion failed");

`endif

[rtl/rhn_pkg.sv]
// Types, constants and helper functions of the RGB histogram normalizer.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package rhn_pkg;

    localparam int BINS       = 16;
    localparam int COUNT_W    = 23;
    localparam int LEVEL_W    = 8;
    localparam int BIN_W      = 4;
    localparam int PLANE_W    = 2;
    localparam int NUM_PLANES = 3;
    localparam int Q_W        = 16;
    localparam int PROD_W     = 2 * COUNT_W;
    localparam int SUM_W      = 2 * COUNT_W + 6;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int REM_W      = ROOT_W + 1;
    localparam int DSTEP_W    = $clog2(Q_W);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [Q_W-1:0] Q_ONE = Q_W'(32768);

    typedef logic [BIN_W-1:0]   bin_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] blue_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] red_level;
        logic               last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [Q_W-1:0]     normalized_value;
        logic [PLANE_W-1:0] color_plane;
        bin_t               bin_number;
        logic               final_value;
    } result_t;

    typedef struct packed {
        bin_t blue_bin;
        bin_t green_bin;
        bin_t red_bin;
        logic last;
    } bin_item_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_SUM,
        ST_ROOT,
        ST_DIV,
        ST_PUT
    } back_state_t;

    function automatic bin_t level_to_bin(input logic [LEVEL_W-1:0] level);
        logic [LEVEL_W+BIN_W:0] prod;
        prod = {1'b0, level, {BIN_W{1'b0}}} >> BIN_W;
        prod = prod * (LEVEL_W + BIN_W + 1)'(BINS);
        return BIN_W'(prod >> LEVEL_W);
    endfunction

    function automatic count_t sat_inc(input count_t c);
        return (&c) ? c : c + COUNT_W'(1);
    endfunction

endpackage

[rtl/rhn_fifo.sv]
// Small flop-based queue of classified pixels between front and back.
// Depends on rhn_pkg.
`timescale 1ns / 1ps

module rhn_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  rhn_pkg::bin_item_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output rhn_pkg::bin_item_t pop_data
);
    import rhn_pkg::*;

    bin_item_t              slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]       fill_reg, fill_next;
    logic                   do_push, do_pop;

    assign push_ready = (fill_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + (FIFO_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/rhn_front.sv]
// Front end: takes pixels and maps each color level to its histogram bin.
// Depends on rhn_pkg.
`timescale 1ns / 1ps

module rhn_front (
    input  logic               s_valid,
    output logic               s_ready,
    input  rhn_pkg::pixel_t    s_data,
    output logic               push_valid,
    input  logic               push_ready,
    output rhn_pkg::bin_item_t push_data
);
    import rhn_pkg::*;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    always_comb begin
        push_data.blue_bin  = level_to_bin(s_data.blue_level);
        push_data.green_bin = level_to_bin(s_data.green_level);
        push_data.red_bin   = level_to_bin(s_data.red_level);
        push_data.last      = s_data.last_pixel;
    end

endmodule

[rtl/rhn_back.sv]
// Back end: histogram counters, sum of squares, square root and division.
// Depends on rhn_pkg.
`timescale 1ns / 1ps

module rhn_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  rhn_pkg::bin_item_t pop_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rhn_pkg::result_t   m_data
);
    import rhn_pkg::*;

    back_state_t          state_reg, state_next;
    count_t               hist_reg [NUM_PLANES][BINS];
    count_t               hist_next [NUM_PLANES][BINS];
    logic [PLANE_W-1:0]   plane_reg, plane_next;
    bin_t                 bin_reg, bin_next;
    logic                 walk_done_reg, walk_done_next;
    count_t               sq_reg, sq_next;
    logic                 sq_vld_reg, sq_vld_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic                 prod_vld_reg, prod_vld_next;
    logic [SUM_W-1:0]     acc_reg, acc_next;
    logic [SUM_W-1:0]     x_reg, x_next;
    logic [SUM_W-1:0]     res_reg, res_next;
    logic [SUM_W-1:0]     bit_reg, bit_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [Q_W-1:0]       q_reg, q_next;
    logic [DSTEP_W-1:0]   dstep_reg, dstep_next;
    logic                 m_valid_reg, m_valid_next;
    result_t              m_data_reg, m_data_next;

    logic                 take;
    logic                 at_end;
    logic [PLANE_W-1:0]   step_plane;
    bin_t                 step_bin;
    logic [SUM_W-1:0]     trial;
    logic [ROOT_W-1:0]    root;
    logic [REM_W-1:0]     shifted;
    logic                 fits;
    logic                 out_free;
    logic                 sum_drained;

    assign take        = pop_valid && pop_ready;
    assign at_end      = (plane_reg == PLANE_W'(NUM_PLANES - 1)) && (bin_reg == BIN_W'(BINS - 1));
    assign step_bin    = (bin_reg == BIN_W'(BINS - 1)) ? '0 : bin_reg + BIN_W'(1);
    assign step_plane  = (bin_reg == BIN_W'(BINS - 1)) ? plane_reg + PLANE_W'(1) : plane_reg;
    assign trial       = res_reg + bit_reg;
    assign root        = res_reg[ROOT_W-1:0];
    assign shifted     = (dstep_reg == '0) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
    assign fits        = (shifted >= REM_W'(root));
    assign out_free    = !m_valid_reg || m_ready;
    assign sum_drained = walk_done_reg && !sq_vld_reg && !prod_vld_reg;
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_ACCUM: begin
                if (take && pop_data.last) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                if (sum_drained) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (bit_reg == '0) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (dstep_reg == DSTEP_W'(Q_W - 1)) begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                if (out_free) begin
                    state_next = at_end ? ST_ACCUM : ST_DIV;
                end
            end
            default: state_next = ST_ACCUM;
        endcase
    end

    // State outputs.
    always_comb begin
        pop_ready = (state_reg == ST_ACCUM);
    end

    // Datapath.
    always_comb begin
        hist_next      = hist_reg;
        plane_next     = plane_reg;
        bin_next       = bin_reg;
        walk_done_next = walk_done_reg;
        sq_next        = hist_reg[plane_reg][bin_reg];
        sq_vld_next    = 1'b0;
        prod_next      = PROD_W'(sq_reg) * PROD_W'(sq_reg);
        prod_vld_next  = sq_vld_reg;
        acc_next       = acc_reg;
        x_next         = x_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        dstep_next     = dstep_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        case (state_reg)
            ST_ACCUM: begin
                if (take) begin
                    hist_next[0][pop_data.blue_bin] =
                        sat_inc(hist_reg[0][pop_data.blue_bin]);
                    hist_next[1][pop_data.green_bin] =
                        sat_inc(hist_reg[1][pop_data.green_bin]);
                    hist_next[2][pop_data.red_bin] =
                        sat_inc(hist_reg[2][pop_data.red_bin]);
                end
                plane_next     = '0;
                bin_next       = '0;
                walk_done_next = 1'b0;
                acc_next       = '0;
            end
            ST_SUM: begin
                if (!walk_done_reg) begin
                    sq_vld_next    = 1'b1;
                    plane_next     = step_plane;
                    bin_next       = step_bin;
                    walk_done_next = at_end;
                end
                if (prod_vld_reg) begin
                    acc_next = acc_reg + SUM_W'(prod_reg);
                end
                x_next   = acc_reg;
                res_next = '0;
                bit_next = SUM_W'(1) << (SUM_W - 2);
            end
            ST_ROOT: begin
                if (bit_reg != '0) begin
                    if (x_reg >= trial) begin
                        x_next   = x_reg - trial;
                        res_next = (res_reg >> 1) + bit_reg;
                    end else begin
                        res_next = res_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
                plane_next = '0;
                bin_next   = '0;
                rem_next   = REM_W'(hist_reg[0][0]);
                dstep_next = '0;
                q_next     = '0;
            end
            ST_DIV: begin
                rem_next   = fits ? shifted - REM_W'(root) : shifted;
                q_next     = {q_reg[Q_W-2:0], fits};
                dstep_next = dstep_reg + DSTEP_W'(1);
            end
            ST_PUT: begin
                if (out_free) begin
                    m_valid_next                 = 1'b1;
                    m_data_next.normalized_value = (root == '0) ? '0 :
                        ((q_reg > Q_ONE) ? Q_ONE : q_reg);
                    m_data_next.color_plane      = plane_reg;
                    m_data_next.bin_number       = bin_reg;
                    m_data_next.final_value      = at_end;
                    plane_next                   = step_plane;
                    bin_next                     = step_bin;
                    rem_next   = REM_W'(hist_reg[step_plane][step_bin]);
                    dstep_next = '0;
                    q_next     = '0;
                    if (at_end) begin
                        for (int p = 0; p < NUM_PLANES; p++) begin
                            for (int b = 0; b < BINS; b++) begin
                                hist_next[p][b] = '0;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACCUM;
            walk_done_reg <= 1'b0;
            sq_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int p = 0; p < NUM_PLANES; p++) begin
                for (int b = 0; b < BINS; b++) begin
                    hist_reg[p][b] <= '0;
                end
            end
        end else begin
            state_reg     <= state_next;
            walk_done_reg <= walk_done_next;
            sq_vld_reg    <= sq_vld_next;
            prod_vld_reg  <= prod_vld_next;
            m_valid_reg   <= m_valid_next;
            hist_reg      <= hist_next;
        end
    end

    always_ff @(posedge aclk) begin
        plane_reg  <= plane_next;
        bin_reg    <= bin_next;
        sq_reg     <= sq_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        x_reg      <= x_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        dstep_reg  <= dstep_next;
        m_data_reg <= m_data_next;
    end

endmodule

[rtl/rgb_histogram_l2_normalizer_top.sv]
// RGB histogram normalizer: pixels in, 48 normalized histogram bins out.
// Top level; uses rhn_pkg, rhn_front, rhn_fifo, rhn_back, assert_macros.svh.
`timescale 1ns / 1ps

// The block counts blue, green and red levels of an image into three
// 16-bin histograms, one pixel item per clock while it is counting, with
// saturating counters. The item carrying last_pixel is counted, and the
// block then walks all 48 counts through a registered squarer, takes the
// integer square root bit by bit, and divides each count, scaled to Q1.15,
// by that root in a restoring divider that retires one quotient bit per
// cycle; each quotient is then loaded into the output register. Results
// leave in blue, green, red and bin order, final_value marks the last one,
// and the histograms are then cleared for the next image. A four-item
// queue sits between the pixel front end and the counter back end; while
// the back end normalizes, pixels of the next image fill that queue and
// then s_ready drops until the last result has been loaded into the
// output register.
module rgb_histogram_l2_normalizer_top (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  rhn_pkg::pixel_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output rhn_pkg::result_t m_data
);
    import rhn_pkg::*;

`include "assert_macros.svh"

    logic      push_valid;
    logic      push_ready;
    bin_item_t push_data;
    logic      pop_valid;
    logic      pop_ready;
    bin_item_t pop_data;

    // Classify pixels into bin numbers.
    rhn_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouples pixel intake from the normalization walk.
    rhn_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Counting, sum of squares, square root and division.
    rhn_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // A normalized count never exceeds one in Q1.15.
    `RHN_ASSERT(a_value_range, m_valid |-> (m_data.normalized_value <= Q_ONE))
    // The final flag appears only on the last bin of the red plane.
    `RHN_ASSERT(a_final_pos, (m_valid && m_data.final_value) |-> ((m_data.color_plane == PLANE_W'(NUM_PLANES - 1)) && (m_data.bin_number == BIN_W'(BINS - 1))))
    // Only real planes are reported.
    `RHN_ASSERT(a_plane_range, m_valid |-> (m_data.color_plane != PLANE_W'(NUM_PLANES)))

endmodule

[tb/tb_rgb_histogram_l2_normalizer_top.sv]
// Self-checking testbench of the RGB histogram normalizer top level.
// Depends on rhn_pkg and rgb_histogram_l2_normalizer_top; needs nothing else.
`timescale 1ns / 1ps

module tb_rgb_histogram_l2_normalizer_top;
    import rhn_pkg::*;

    localparam int HIST_N = NUM_PLANES * BINS;

    logic    aclk;
    logic    aresetn;
    logic    s_valid;
    logic    s_ready;
    pixel_t  s_data;
    logic    m_valid;
    logic    m_ready;
    result_t m_data;

    rgb_histogram_l2_normalizer_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // The predictor keeps its own histograms, one flat array over the planes.
    logic [COUNT_W-1:0] hist_model [HIST_N];
    result_t            bins_due [$];

    int      send_idle_pct;
    int      recv_idle_pct;
    int      errors;
    int      pixels_sent;
    int      images_done;
    int      bins_checked;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // The run is bounded by a long fixed time; the slowest correct run needs
    // far less, even if every pixel closed an image under heavy stalls.
    initial begin
        #20_000_000;
        $display("Timeout at %0t.", $time);
        $display("*** FAILED ***");
        $finish;
    end

    // Floor square root, computed bit by bit on a 64-bit value.
    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic int bin_of(input logic [LEVEL_W-1:0] lvl);
        return (int'(lvl) * BINS) / 256;
    endfunction

    function automatic void count_in(input int idx);
        if (hist_model[idx] != {COUNT_W{1'b1}}) hist_model[idx] = hist_model[idx] + 1'b1;
    endfunction

    // Counts one pixel and, on the last pixel of an image, queues the 48
    // normalized bins that the block must emit, then clears the histograms.
    function automatic void predict_pixel(input pixel_t px);
        logic [63:0] sum_sq;
        logic [63:0] root;
        logic [63:0] q;
        result_t     r;
        count_in(bin_of(px.blue_level));
        count_in(BINS + bin_of(px.green_level));
        count_in(2 * BINS + bin_of(px.red_level));
        if (!px.last_pixel) return;
        sum_sq = 64'd0;
        for (int i = 0; i < HIST_N; i++) sum_sq += 64'(hist_model[i]) * 64'(hist_model[i]);
        root = floor_root(sum_sq);
        for (int i = 0; i < HIST_N; i++) begin
            q = (root == 0) ? 64'd0 : (64'(hist_model[i]) * 64'd32768) / root;
            if (q > 64'd32768) q = 64'd32768;
            r.normalized_value = q[Q_W-1:0];
            r.color_plane      = PLANE_W'(i / BINS);
            r.bin_number       = BIN_W'(i % BINS);
            r.final_value      = (i == HIST_N - 1);
            bins_due.push_back(r);
            hist_model[i] = '0;
        end
    endfunction

    // Drives one pixel item at the falling edge and holds it until accepted.
    // Items that follow back to back keep s_valid high without a dip.
    task automatic send_pixel(input pixel_t px);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pixel(px);
        pixels_sent++;
        @(negedge aclk);
    endtask

    function automatic pixel_t rand_pixel(input logic last);
        pixel_t px;
        px.blue_level  = LEVEL_W'($urandom);
        px.green_level = LEVEL_W'($urandom);
        px.red_level   = LEVEL_W'($urandom);
        px.last_pixel  = last;
        return px;
    endfunction

    function automatic pixel_t make_pixel(input logic [7:0] b, input logic [7:0] g,
                                          input logic [7:0] rd, input logic last);
        pixel_t px;
        px.blue_level  = b;
        px.green_level = g;
        px.red_level   = rd;
        px.last_pixel  = last;
        return px;
    endfunction

    // The receiver stalls at random at each falling edge.
    always @(negedge aclk) begin
        if (aresetn)
            m_ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
    end

    // Every accepted result is matched against the oldest queued bin.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (bins_due.size() == 0) begin
                $display("%0t: result %h arrived with nothing expected.", $time, m_data);
                errors++;
            end else begin
                result_t e;
                e = bins_due.pop_front();
                if (m_data.normalized_value !== e.normalized_value) begin
                    $display("%0t: normalized_value expected %0d, got %0d.",
                             $time, e.normalized_value, m_data.normalized_value);
                    errors++;
                end
                if (m_data.color_plane !== e.color_plane) begin
                    $display("%0t: color_plane expected %0d, got %0d.",
                             $time, e.color_plane, m_data.color_plane);
                    errors++;
                end
                if (m_data.bin_number !== e.bin_number) begin
                    $display("%0t: bin_number expected %0d, got %0d.",
                             $time, e.bin_number, m_data.bin_number);
                    errors++;
                end
                if (m_data.final_value !== e.final_value) begin
                    $display("%0t: final_value expected %0d, got %0d.",
                             $time, e.final_value, m_data.final_value);
                    errors++;
                end
                bins_checked++;
                if (e.final_value) images_done++;
            end
        end
    end

    // Walks the bin boundaries of all three planes, including both level
    // extremes, and closes the image with a single last pixel.
    task automatic test_bin_edges();
        for (int k = 0; k < BINS; k++) begin
            send_pixel(make_pixel(8'(k * 16), 8'(k * 16 + 15), 8'(255 - k * 16), 1'b0));
        end
        send_pixel(make_pixel(8'h00, 8'hFF, 8'h80, 1'b0));
        send_pixel(make_pixel(8'hFF, 8'h00, 8'h7F, 1'b1));
    endtask

    // Two images of one pixel each: each plane has a single bin with count
    // one, which normalizes to one, and every other bin is zero.
    task automatic test_single_pixel_image();
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b1));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1));
    endtask

    // Images of random size and content; mostly small, a few longer ones.
    task automatic test_random_images(input int pixels);
        int left;
        int len;
        left = pixels;
        while (left > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
            if (len > left) len = left;
            for (int i = 0; i < len; i++) send_pixel(rand_pixel(i == len - 1));
            left -= len;
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (bins_due.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 49;
        errors        = 0;
        pixels_sent   = 0;
        images_done   = 0;
        bins_checked  = 0;
        for (int i = 0; i < HIST_N; i++) hist_model[i] = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_bin_edges();
        test_single_pixel_image();
        test_random_images(50);
        send_idle_pct = 49;
        recv_idle_pct = 18;
        test_random_images(60);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_images(50);
        drain();

        $display("Sent %0d pixels in %0d images: bin edges, one-pixel images, random images.",
                 pixels_sent, images_done);
        $display("Checked %0d normalized bins.", bins_checked);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[rgb_histogram_l2_normalizer_top.f]
+incdir+rtl
rtl/rhn_pkg.sv
rtl/rhn_fifo.sv
rtl/rhn_front.sv
rtl/rhn_back.sv
rtl/rgb_histogram_l2_normalizer_top.sv
tb/tb_rgb_histogram_l2_normalizer_top.sv
